/* hdl/vmp_pkg.sv */
// Shared types, constants and the 5-bit to 8-bit color table for the video memory port.
package vmp_pkg;

	localparam int VMP_LINES_PER_FRAME = 262;
	localparam int VMP_VBLANK_LINE     = 225;
	localparam int VMP_VIDEO_WORDS     = 32768;

	localparam int VMP_ADDR_W = 15;
	localparam int VMP_LINE_W = 9;
	// quotient of a 15-bit address by the smallest allowed store depth (1024) fits in 5 bits
	localparam int VMP_QUOT_W      = 5;
	localparam int VMP_RECIP_W     = 22;
	localparam int VMP_RECIP_SHIFT = 31;

	localparam int VMP_CMD_DEPTH   = 2;
	localparam int VMP_CMD_CNT_W   = $clog2(VMP_CMD_DEPTH + 1);
	localparam int VMP_RES_DEPTH   = 4;
	localparam int VMP_RES_CNT_W   = $clog2(VMP_RES_DEPTH + 1);

	localparam logic [2:0] MODE_VID_LO = 3'd0;
	localparam logic [2:0] MODE_VID_HI = 3'd1;
	localparam logic [2:0] MODE_VID_RD = 3'd2;
	localparam logic [2:0] MODE_PAL_WR = 3'd3;
	localparam logic [2:0] MODE_PAL_RD = 3'd4;
	localparam logic [2:0] MODE_TICK   = 3'd5;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_VID_WR_LO,
		OP_VID_WR_HI,
		OP_VID_RD,
		OP_PAL_WR,
		OP_PAL_RD
	} op_t;

	typedef struct packed {
		op_t                       op;
		logic [VMP_ADDR_W-1:0]     addr;
		logic [VMP_QUOT_W-1:0]     quot;
		logic [15:0]               wdata;
		logic                      committed;
		logic                      nmi;
		logic                      vblank;
		logic [VMP_LINE_W-1:0]     line;
	} cmd_t;

	typedef struct packed {
		logic [15:0]           read_word;
		logic [31:0]           rgba;
		logic                  committed;
		logic                  nmi;
		logic                  vblank;
		logic [VMP_LINE_W-1:0] line;
	} res_t;

	// c*255/31, truncated
	localparam logic [7:0] EXPAND5 [32] = '{
		8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
		8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
		8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
		8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
	};

	function automatic logic [31:0] to_rgba(input logic [15:0] w);
		return {EXPAND5[w[4:0]], EXPAND5[w[9:5]], EXPAND5[w[14:10]], 8'hff};
	endfunction

endpackage

/* hdl/vmp_ram.sv */
// Generic single-port RAM with registered read.
module vmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/vmp_queue.sv */
// Small register-based FIFO used between front, back and result port.
module vmp_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [W-1:0]               wdata,
	input  logic                       pop,
	output logic [W-1:0]               rdata,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

/* hdl/vmp_front.sv */
// Front end: accepts items, runs the palette byte latch and scanline timing, emits commands.
module vmp_front #(
	parameter int LINES_PER_FRAME = vmp_pkg::VMP_LINES_PER_FRAME,
	parameter int VBLANK_LINE     = vmp_pkg::VMP_VBLANK_LINE,
	parameter int VIDEO_WORDS     = vmp_pkg::VMP_VIDEO_WORDS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic [2:0]   mode,
	input  logic [15:0]  address,
	input  logic [7:0]   write_byte,
	input  logic         cmd_full,
	output logic         cmd_push,
	output vmp_pkg::cmd_t cmd
);

	import vmp_pkg::*;

	localparam int PROD_W = VMP_ADDR_W + VMP_RECIP_W;
	// floor(2^31 / depth): quotient estimate is exact or one low, fixed up in the back end
	localparam logic [VMP_RECIP_W-1:0] RECIP =
		VMP_RECIP_W'((64'd1 << VMP_RECIP_SHIFT) / VIDEO_WORDS);

	logic                  accept;
	logic                  toggle_q;
	logic                  toggle_d;
	logic [7:0]            first_q;
	logic [7:0]            first_d;
	logic [VMP_LINE_W-1:0] line_q;
	logic [VMP_LINE_W-1:0] line_d;
	logic [VMP_LINE_W-1:0] line_inc;
	logic                  vblank_q;
	logic                  vblank_d;
	logic                  nmi_q;
	logic                  nmi_d;
	logic [VMP_ADDR_W-1:0] addr_m;
	logic [PROD_W-1:0]     prod;
	op_t                   op;
	logic [15:0]           wdata;
	logic                  committed;

	assign accept   = push && !cmd_full;
	assign full     = cmd_full;
	assign cmd_push = accept;
	assign addr_m   = address[VMP_ADDR_W-1:0];
	assign prod     = PROD_W'(addr_m) * PROD_W'(RECIP);
	assign line_inc = line_q + VMP_LINE_W'(1);

	always_comb begin
		toggle_d  = toggle_q;
		first_d   = first_q;
		line_d    = line_q;
		vblank_d  = vblank_q;
		nmi_d     = nmi_q;
		op        = OP_NONE;
		wdata     = '0;
		committed = 1'b0;
		unique case (mode)
			MODE_VID_LO: begin
				op    = OP_VID_WR_LO;
				wdata = {write_byte, write_byte};
			end
			MODE_VID_HI: begin
				op    = OP_VID_WR_HI;
				wdata = {write_byte, write_byte};
			end
			MODE_VID_RD: begin
				op = OP_VID_RD;
			end
			MODE_PAL_WR: begin
				if (!toggle_q) begin
					toggle_d = 1'b1;
					first_d  = write_byte;
				end else begin
					toggle_d  = 1'b0;
					op        = OP_PAL_WR;
					wdata     = {write_byte, first_q};
					committed = 1'b1;
				end
			end
			MODE_PAL_RD: begin
				op = OP_PAL_RD;
			end
			MODE_TICK: begin
				// vblank start is tested before the frame wrap
				if (line_inc == VMP_LINE_W'(VBLANK_LINE)) begin
					line_d   = line_inc;
					vblank_d = 1'b1;
					nmi_d    = 1'b1;
				end else if (line_inc >= VMP_LINE_W'(LINES_PER_FRAME)) begin
					line_d   = line_inc - VMP_LINE_W'(LINES_PER_FRAME);
					vblank_d = 1'b0;
					nmi_d    = 1'b0;
				end else begin
					line_d = line_inc;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		cmd.op        = op;
		cmd.addr      = addr_m;
		cmd.quot      = prod[VMP_RECIP_SHIFT +: VMP_QUOT_W];
		cmd.wdata     = wdata;
		cmd.committed = committed;
		cmd.nmi       = nmi_d;
		cmd.vblank    = vblank_d;
		cmd.line      = line_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			toggle_q <= 1'b0;
			first_q  <= '0;
			line_q   <= '0;
			vblank_q <= 1'b0;
			nmi_q    <= 1'b0;
		end else if (accept) begin
			toggle_q <= toggle_d;
			first_q  <= first_d;
			line_q   <= line_d;
			vblank_q <= vblank_d;
			nmi_q    <= nmi_d;
		end
	end

endmodule

/* hdl/vmp_back.sv */
// Back end: video and palette RAM accesses, color expansion, result assembly.
module vmp_back #(
	parameter int VIDEO_WORDS = vmp_pkg::VMP_VIDEO_WORDS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_empty,
	input  vmp_pkg::cmd_t                      cmd,
	output logic                               cmd_pop,
	input  logic [vmp_pkg::VMP_RES_CNT_W-1:0]  res_count,
	output logic                               res_push,
	output vmp_pkg::res_t                      res
);

	import vmp_pkg::*;

	localparam int AW = $clog2(VIDEO_WORDS);
	localparam int OW = VMP_RES_CNT_W + 1;

	logic [15:0]           base;
	logic [15:0]           rem_raw;
	logic [15:0]           rem;
	logic [AW-1:0]         vid_idx;
	logic [OW-1:0]         occupancy;
	logic                  issue;
	logic [7:0]            lo_rd;
	logic [7:0]            hi_rd;
	logic [15:0]           pal_rd;
	logic                  valid_s1;
	op_t                   op_s1;
	logic                  committed_s1;
	logic                  nmi_s1;
	logic                  vblank_s1;
	logic [VMP_LINE_W-1:0] line_s1;

	// address mod depth: subtract the estimated multiple, then at most one more depth
	assign base    = 16'(cmd.quot) * 16'(VIDEO_WORDS);
	assign rem_raw = {1'b0, cmd.addr} - base;
	assign rem     = (rem_raw >= 16'(VIDEO_WORDS)) ? rem_raw - 16'(VIDEO_WORDS) : rem_raw;
	assign vid_idx = rem[AW-1:0];

	// issue only if the result queue has room for everything in flight
	assign occupancy = {1'b0, res_count} + OW'(valid_s1);
	assign issue     = !cmd_empty && (occupancy < OW'(VMP_RES_DEPTH));
	assign cmd_pop   = issue;

	// video words live in two byte banks so byte writes need no read-modify-write
	vmp_ram #(.WIDTH(8), .DEPTH(VIDEO_WORDS)) u_vid_lo (
		.clk   (clk),
		.we    (issue && (cmd.op == OP_VID_WR_LO)),
		.addr  (vid_idx),
		.wdata (cmd.wdata[7:0]),
		.rdata (lo_rd)
	);

	vmp_ram #(.WIDTH(8), .DEPTH(VIDEO_WORDS)) u_vid_hi (
		.clk   (clk),
		.we    (issue && (cmd.op == OP_VID_WR_HI)),
		.addr  (vid_idx),
		.wdata (cmd.wdata[15:8]),
		.rdata (hi_rd)
	);

	vmp_ram #(.WIDTH(16), .DEPTH(256)) u_pal (
		.clk   (clk),
		.we    (issue && (cmd.op == OP_PAL_WR)),
		.addr  (cmd.addr[7:0]),
		.wdata (cmd.wdata),
		.rdata (pal_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			op_s1        <= cmd.op;
			committed_s1 <= cmd.committed;
			nmi_s1       <= cmd.nmi;
			vblank_s1    <= cmd.vblank;
			line_s1      <= cmd.line;
		end
	end

	assign res_push = valid_s1;

	always_comb begin
		res.read_word = '0;
		res.rgba      = '0;
		res.committed = committed_s1;
		res.nmi       = nmi_s1;
		res.vblank    = vblank_s1;
		res.line      = line_s1;
		case (op_s1)
			OP_VID_RD: begin
				res.read_word = {hi_rd, lo_rd};
			end
			OP_PAL_RD: begin
				res.read_word = pal_rd;
				res.rgba      = to_rgba(pal_rd);
			end
			default: begin
			end
		endcase
	end

endmodule

/* hdl/video_memory_port_with_palette.sv */
// Top level of the video memory port: front end, command queue, back end, result queue.
// Items enter through a queue-style port and each yields one result on the result queue,
// in order. The block sustains one item per clock while the command queue is not full:
// each item makes at most one access to the video RAM (two byte banks, VIDEO_WORDS deep)
// or the 256-entry palette RAM. Between the accepting edge and the result ports lie the
// command queue, the registered RAM read and the result queue. Palette and scanline state
// are updated at accept time by the front end; a two-entry command queue and a four-entry
// result queue let either side stall without stopping the other until they fill. Video and
// palette entries have no reset; reading an entry (or the other byte of a video word) that
// was never written returns undefined data.
module video_memory_port_with_palette #(
	parameter int LINES_PER_FRAME = vmp_pkg::VMP_LINES_PER_FRAME,
	parameter int VBLANK_LINE     = vmp_pkg::VMP_VBLANK_LINE,
	parameter int VIDEO_WORDS     = vmp_pkg::VMP_VIDEO_WORDS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  mode,
	input  logic [15:0] address,
	input  logic [7:0]  write_byte,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] read_word,
	output logic [31:0] rgba,
	output logic        palette_committed,
	output logic        nmi_request,
	output logic        in_vblank,
	output logic [8:0]  line_number
);

	import vmp_pkg::*;

	logic                     cmd_push;
	logic                     cmd_full;
	logic                     cmd_empty;
	logic                     cmd_pop;
	logic [VMP_CMD_CNT_W-1:0] cmd_count;
	cmd_t                     cmd_in;
	cmd_t                     cmd_out;
	logic                     res_push;
	logic                     res_full;
	logic [VMP_RES_CNT_W-1:0] res_count;
	res_t                     res_in;
	res_t                     res_out;

	vmp_front #(
		.LINES_PER_FRAME (LINES_PER_FRAME),
		.VBLANK_LINE     (VBLANK_LINE),
		.VIDEO_WORDS     (VIDEO_WORDS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.mode       (mode),
		.address    (address),
		.write_byte (write_byte),
		.cmd_full   (cmd_full),
		.cmd_push   (cmd_push),
		.cmd        (cmd_in)
	);

	vmp_queue #(.W($bits(cmd_t)), .DEPTH(VMP_CMD_DEPTH)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.full   (cmd_full),
		.empty  (cmd_empty),
		.count  (cmd_count)
	);

	vmp_back #(.VIDEO_WORDS(VIDEO_WORDS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_count (res_count),
		.res_push  (res_push),
		.res       (res_in)
	);

	vmp_queue #(.W($bits(res_t)), .DEPTH(VMP_RES_DEPTH)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.pop    (pop),
		.rdata  (res_out),
		.full   (res_full),
		.empty  (empty),
		.count  (res_count)
	);

	assign read_word         = res_out.read_word;
	assign rgba              = res_out.rgba;
	assign palette_committed = res_out.committed;
	assign nmi_request       = res_out.nmi;
	assign in_vblank         = res_out.vblank;
	assign line_number       = res_out.line;

	a_no_cmd_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> (cmd_count < VMP_CMD_CNT_W'(VMP_CMD_DEPTH)))
		else $error("command pushed into a full command queue");

	a_no_res_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full result queue");

	// the line can sit at the frame length only when vblank starts on that line
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (line_number <= 9'(LINES_PER_FRAME)))
		else $error("scanline beyond frame length");

	a_nmi_follows_vblank: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (nmi_request == in_vblank))
		else $error("nmi and vblank flags disagree");

	a_commit_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && palette_committed) |-> (read_word == 16'd0 && rgba == 32'd0))
		else $error("palette write item carries read data");

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the video memory port: directed, frame timing, random and stall tests.
module testbench;
	import vmp_pkg::*;

	localparam logic [2:0] MODE_SPARE_A = 3'd6;
	localparam logic [2:0] MODE_SPARE_B = 3'd7;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [15:0] word;
		logic [31:0] colour;
		logic        committed;
		logic        nmi;
		logic        vblank;
		logic [8:0]  line;
	} port_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [2:0]  mode = '0;
	logic [15:0] address = '0;
	logic [7:0]  write_byte = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [15:0] read_word;
	logic [31:0] rgba;
	logic        palette_committed;
	logic        nmi_request;
	logic        in_vblank;
	logic [8:0]  line_number;

	video_memory_port_with_palette u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.mode(mode),
		.address(address),
		.write_byte(write_byte),
		.empty(empty),
		.pop(pop),
		.read_word(read_word),
		.rgba(rgba),
		.palette_committed(palette_committed),
		.nmi_request(nmi_request),
		.in_vblank(in_vblank),
		.line_number(line_number)
	);

	// predicted chip state
	logic [15:0] video_words [VMP_VIDEO_WORDS];
	bit   [1:0]  word_bytes_written [VMP_VIDEO_WORDS];
	logic [15:0] palette_words [256];
	bit          palette_written [256];
	logic        pal_toggle = 1'b0;
	logic [7:0]  pal_low_byte = '0;
	logic [8:0]  line_count = '0;
	logic        vblank_now = 1'b0;
	logic        nmi_now = 1'b0;

	int filled_words[$];
	int filled_entries[$];
	port_result_t pending_results[$];

	int frames_done = 0;
	int items_sent = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;
	bit hold_req = 1'b0;
	logic hold_on = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [7:0] expand_channel(input logic [4:0] c);
		return 8'((int'(c) * 255) / 31);
	endfunction

	task automatic compute_port_result(input logic [2:0] m, input logic [15:0] a,
			input logic [7:0] b);
		port_result_t r;
		int vi;
		int pi;
		r = '0;
		vi = int'(a[14:0]) % VMP_VIDEO_WORDS;
		pi = int'(a[7:0]);
		case (m)
			MODE_VID_LO: begin
				video_words[vi][7:0] = b;
				if (word_bytes_written[vi] == 2'b10)
					filled_words.push_back(vi);
				word_bytes_written[vi][0] = 1'b1;
			end
			MODE_VID_HI: begin
				video_words[vi][15:8] = b;
				if (word_bytes_written[vi] == 2'b01)
					filled_words.push_back(vi);
				word_bytes_written[vi][1] = 1'b1;
			end
			MODE_VID_RD: r.word = video_words[vi];
			MODE_PAL_WR: begin
				if (!pal_toggle) begin
					pal_low_byte = b;
					pal_toggle = 1'b1;
				end else begin
					palette_words[pi] = {b, pal_low_byte};
					if (!palette_written[pi])
						filled_entries.push_back(pi);
					palette_written[pi] = 1'b1;
					pal_toggle = 1'b0;
					r.committed = 1'b1;
				end
			end
			MODE_PAL_RD: begin
				r.word = palette_words[pi];
				// bit 15 is kept in the word but not in the color
				r.colour = {expand_channel(palette_words[pi][4:0]),
					expand_channel(palette_words[pi][9:5]),
					expand_channel(palette_words[pi][14:10]), 8'hff};
			end
			MODE_TICK: begin
				line_count = line_count + 9'd1;
				if (int'(line_count) == VMP_VBLANK_LINE) begin
					vblank_now = 1'b1;
					nmi_now = 1'b1;
				end else if (int'(line_count) >= VMP_LINES_PER_FRAME) begin
					line_count = 9'(int'(line_count) - VMP_LINES_PER_FRAME);
					vblank_now = 1'b0;
					nmi_now = 1'b0;
					frames_done++;
				end
			end
			default: ;
		endcase
		r.nmi = nmi_now;
		r.vblank = vblank_now;
		r.line = line_count;
		pending_results.push_back(r);
	endtask

	task automatic send_item(input logic [2:0] m, input logic [15:0] a, input logic [7:0] b);
		while ($urandom_range(99) < sender_idle_pct) begin
			push <= 1'b0;
			mode <= 3'($urandom);
			address <= 16'($urandom);
			write_byte <= 8'($urandom);
			@(posedge clk);
		end
		push <= 1'b1;
		mode <= m;
		address <= a;
		write_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (m <= MODE_TICK)
			items_sent++;
		compute_port_result(m, a, b);
	endtask

	task automatic wait_all_results();
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic compare_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	task automatic check_result();
		port_result_t e;
		if (pending_results.size() == 0) begin
			$error("result popped with no item outstanding");
			mismatches++;
		end else begin
			e = pending_results.pop_front();
			compare_field("read_word", 32'(e.word), 32'(read_word));
			compare_field("rgba", e.colour, rgba);
			compare_field("palette_committed", 32'(e.committed), 32'(palette_committed));
			compare_field("nmi_request", 32'(e.nmi), 32'(nmi_request));
			compare_field("in_vblank", 32'(e.vblank), 32'(in_vblank));
			compare_field("line_number", 32'(e.line), 32'(line_number));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			check_result();
		if (hold_on)
			pop <= 1'b0;
		else
			pop <= ($urandom_range(99) >= receiver_idle_pct);
	end

	// long receiver stall, timed here
	always begin
		wait (hold_req);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
		hold_req = 1'b0;
	end

	// one random operation; reads only target fully written entries
	task automatic send_random_op();
		int pick;
		logic [15:0] a;
		logic [7:0] b;
		pick = $urandom_range(99);
		a = 16'($urandom);
		b = 8'($urandom);
		if (pick < 20) begin
			if ($urandom_range(1) == 1) begin
				send_item(MODE_VID_LO, a, b);
				send_item(MODE_VID_HI, a, 8'($urandom));
			end else begin
				send_item(MODE_VID_HI, a, b);
				send_item(MODE_VID_LO, a, 8'($urandom));
			end
		end else if (pick < 35) begin
			if (filled_words.size() > 0) begin
				a = {1'($urandom_range(1)),
					15'(filled_words[$urandom_range(filled_words.size() - 1)])};
				send_item(MODE_VID_RD, a, b);
			end else
				send_item(MODE_TICK, a, b);
		end else if (pick < 50) begin
			if (!pal_toggle)
				send_item(MODE_PAL_WR, 16'($urandom), 8'($urandom));
			send_item(MODE_PAL_WR, a, b);
		end else if (pick < 65) begin
			if (filled_entries.size() > 0) begin
				a = {8'($urandom),
					8'(filled_entries[$urandom_range(filled_entries.size() - 1)])};
				send_item(MODE_PAL_RD, a, b);
			end else
				send_item(MODE_TICK, a, b);
		end else if (pick < 80)
			send_item(MODE_TICK, a, b);
		else if (pick < 88)
			send_item(($urandom_range(1) == 1) ? MODE_VID_HI : MODE_VID_LO, a, b);
		else if (pick < 94)
			// lone palette byte shifts the pairing
			send_item(MODE_PAL_WR, a, b);
		else
			send_item(($urandom_range(1) == 1) ? MODE_SPARE_B : MODE_SPARE_A, a, b);
	endtask

	task automatic test_directed();
		send_item(MODE_VID_LO, 16'h0000, 8'h00);
		send_item(MODE_VID_HI, 16'h0000, 8'hff);
		send_item(MODE_VID_RD, 16'h8000, 8'h00);
		send_item(MODE_VID_HI, 16'hffff, 8'ha5);
		send_item(MODE_VID_LO, 16'h7fff, 8'hff);
		send_item(MODE_VID_RD, 16'hffff, 8'hff);
		// bit 15 of the address aliases onto word 0
		send_item(MODE_VID_LO, 16'h8000, 8'h5a);
		send_item(MODE_VID_RD, 16'h0000, 8'h00);
		// first byte's address is ignored, second selects the entry
		send_item(MODE_PAL_WR, 16'h0012, 8'h34);
		send_item(MODE_PAL_WR, 16'h00ff, 8'h7f);
		send_item(MODE_PAL_RD, 16'h00ff, 8'h00);
		send_item(MODE_PAL_WR, 16'hffff, 8'hff);
		send_item(MODE_PAL_WR, 16'hff00, 8'hff);
		send_item(MODE_PAL_RD, 16'hab00, 8'hff);
		send_item(MODE_PAL_WR, 16'h0000, 8'h00);
		send_item(MODE_PAL_WR, 16'h0080, 8'h00);
		send_item(MODE_PAL_RD, 16'h0080, 8'h00);
		send_item(MODE_SPARE_A, 16'hffff, 8'hff);
		send_item(MODE_SPARE_B, 16'h0000, 8'h00);
		send_item(MODE_TICK, 16'h1234, 8'h56);
	endtask

	// mostly ticks so that vblank start and frame wrap are both crossed
	task automatic test_frame_timing();
		int target;
		target = frames_done + 1;
		while (frames_done < target) begin
			if ($urandom_range(99) < 80)
				send_item(MODE_TICK, 16'($urandom), 8'($urandom));
			else
				send_random_op();
		end
	endtask

	task automatic test_random_traffic(input int count);
		int start;
		start = items_sent;
		while (items_sent - start < count)
			send_random_op();
	endtask

	// receiver stalls long while items keep coming, so full must assert
	task automatic test_fill_and_stall();
		hold_req = 1'b1;
		repeat (40) send_random_op();
		wait_all_results();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		sender_idle_pct = 11;
		receiver_idle_pct = 53;
		test_directed();
		wait_all_results();
		test_frame_timing();

		sender_idle_pct = 53;
		receiver_idle_pct = 11;
		test_random_traffic(60);
		test_fill_and_stall();

		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		test_random_traffic(60);

		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
